@@ rtl/vnfr_pkg.sv @@
// vnfr_pkg: item types, constants and binary32 arithmetic helpers for the
// vector normalise core; no dependencies
package vnfr_pkg;

  typedef struct packed {
    logic [31:0] vec_x;
    logic [31:0] vec_y;
  } vec_in_t;

  typedef struct packed {
    logic [31:0] unit_x;
    logic [31:0] unit_y;
    logic [31:0] inv_norm;
  } vec_out_t;

  localparam logic [31:0] RsqrtMagic = 32'h5f37_5a82;
  localparam logic [31:0] FpHalf     = 32'h3f00_0000;
  localparam logic [31:0] FpThreeHalves = 32'h3fc0_0000;
  localparam logic [31:0] CanonNan   = 32'h7fc0_0000;

  // round a nonzero value m * 2^e to binary32, nearest even, subnormals kept
  function automatic logic [31:0] fp_round_pack(input logic sgn, input logic [49:0] m,
                                                input logic signed [11:0] e);
    logic signed [11:0] p;
    logic signed [11:0] tgt;
    logic signed [11:0] sh;
    logic signed [11:0] be;
    logic [5:0]  amt;
    logic [49:0] kept;
    logic        rnd;
    logic        stk;
    logic [24:0] mant;
    p = '0;
    for (int i = 0; i < 50; i++) begin
      if (m[i]) p = 12'(i);
    end
    tgt = p + e - 12'sd23;
    if (tgt < -12'sd149) tgt = -12'sd149;
    sh = tgt - e;
    rnd = 1'b0;
    stk = 1'b0;
    if (sh > 12'sd50) begin
      kept = '0;
      stk  = |m;
    end else if (sh > 12'sd0) begin
      amt  = sh[5:0];
      kept = m >> amt;
      rnd  = m[amt - 6'd1];
      stk  = |(m & ((50'd1 << (amt - 6'd1)) - 50'd1));
    end else begin
      amt  = 6'(-sh);
      kept = m << amt;
    end
    mant = kept[24:0] + {24'd0, rnd && (stk || kept[0])};
    if (mant[24]) begin
      mant = mant >> 1;
      tgt  = tgt + 12'sd1;
    end
    be = mant[23] ? (tgt + 12'sd150) : 12'sd0;
    if (be >= 12'sd255) begin
      return {sgn, 8'hff, 23'd0};
    end
    return {sgn, be[7:0], mant[22:0]};
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] fp_canon(input logic [31:0] a);
    return fp_is_nan(a) ? CanonNan : a;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        sgn;
    logic        za;
    logic        zb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [47:0] prod;
    sgn = a[31] ^ b[31];
    za  = (a[30:0] == 31'd0);
    zb  = (b[30:0] == 31'd0);
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma  = {a[30:23] != 8'd0, a[22:0]};
    mb  = {b[30:23] != 8'd0, b[22:0]};
    prod = ma * mb;
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && zb) || (za && fp_is_inf(b))) begin
      return CanonNan;
    end
    if (fp_is_inf(a) || fp_is_inf(b)) begin
      return {sgn, 8'hff, 23'd0};
    end
    if (za || zb) begin
      return {sgn, 31'd0};
    end
    return fp_round_pack(sgn, {2'b00, prod},
                         $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd300);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [26:0] mb;
    logic [26:0] ms;
    logic [26:0] msa;
    logic [27:0] sum;
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])))
    begin
      return CanonNan;
    end
    if (fp_is_inf(a)) return a;
    if (fp_is_inf(b)) return b;
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d  = eb - es;
    mb = {big[30:23] != 8'd0, big[22:0], 3'b000};
    ms = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      msa = {26'd0, |ms};
    end else begin
      msa = (ms >> d) | {26'd0, |(ms & ((27'd1 << d) - 27'd1))};
    end
    if (big[31] == sml[31]) sum = {1'b0, mb} + {1'b0, msa};
    else                    sum = {1'b0, mb} - {1'b0, msa};
    if (sum == 28'd0) begin
      return {a[31] & b[31], 31'd0};
    end
    return fp_round_pack(big[31], {22'd0, sum}, $signed({4'd0, eb}) - 12'sd153);
  endfunction

endpackage

@@ rtl/vector2_normalize_fast_rsqrt_core.sv @@
// vector2_normalize_fast_rsqrt_core: pipelined 2d normalise with fast rsqrt
// depends on vnfr_pkg (types, binary32 multiply/add helpers)
//
// Takes one 2d vector (x, y as binary32 bit patterns) per cycle and returns
// x*g, y*g and g, where g approximates 1/sqrt(x*x + y*y): a magic-constant
// guess refined by one newton step, each operation rounded separately to
// nearest even with subnormals kept. NaN results come out as 0x7fc00000.
// Its stages are squares, sum, half and guess, two products, correction,
// refine and scale; throughput is one item per clock. The whole pipeline
// holds while the output item is stalled.
module vector2_normalize_fast_rsqrt_core
  import vnfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  vec_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output vec_out_t out_data_o
);

  // stage valid bits, index 7 is the output register
  logic [7:0]  vld_q;
  logic [7:0]  vld_d;
  logic        adv;

  // operands carried down the pipe
  logic [31:0] x_q [7];
  logic [31:0] y_q [7];
  logic [31:0] xx_q, yy_q, s_q, half_q, g_q [3:6], t1_q, t2_q, corr_q, inv_q;
  vec_out_t    out_q;

  // a stalled output holds everything behind it
  assign adv        = !(vld_q[7] && out_stall_i);
  assign in_stall_o = !adv;
  assign vld_d      = {vld_q[6:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // squares
      x_q[0] <= in_data_i.vec_x;
      y_q[0] <= in_data_i.vec_y;
      xx_q   <= fp_mul(in_data_i.vec_x, in_data_i.vec_x);
      yy_q   <= fp_mul(in_data_i.vec_y, in_data_i.vec_y);
      // squared length
      x_q[1] <= x_q[0];
      y_q[1] <= y_q[0];
      s_q    <= fp_add(xx_q, yy_q);
      // half and magic guess, shift keeps the sign bit
      x_q[2] <= x_q[1];
      y_q[2] <= y_q[1];
      half_q <= fp_mul(FpHalf, s_q);
      g_q[3] <= RsqrtMagic - {s_q[31], s_q[31:1]};
      // newton step
      x_q[3] <= x_q[2];
      y_q[3] <= y_q[2];
      t1_q   <= fp_mul(half_q, g_q[3]);
      g_q[4] <= g_q[3];
      x_q[4] <= x_q[3];
      y_q[4] <= y_q[3];
      t2_q   <= fp_mul(t1_q, g_q[4]);
      g_q[5] <= g_q[4];
      x_q[5] <= x_q[4];
      y_q[5] <= y_q[4];
      corr_q <= fp_add(FpThreeHalves, {~t2_q[31], t2_q[30:0]});
      g_q[6] <= g_q[5];
      x_q[6] <= x_q[5];
      y_q[6] <= y_q[5];
      inv_q  <= fp_mul(g_q[6], corr_q);
      // scale and canonicalise
      out_q.unit_x   <= fp_canon(fp_mul(x_q[6], inv_q));
      out_q.unit_y   <= fp_canon(fp_mul(y_q[6], inv_q));
      out_q.inv_norm <= fp_canon(inv_q);
    end
  end

  assign out_valid_o = vld_q[7];
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // input is held back only by a waiting output item
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // an item in the last working stage reaches the output when the pipe moves
  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[6] && !in_stall_o) |=> out_valid_o)
    else $error("item lost before output register");

  // a stalled output item is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output item changed");
`endif

endmodule
